// ----- src/lhp_pkg.sv -----
// Shared types and constants for the latency histogram percentile core.
package lhp_pkg;

  localparam int NUM_REGS = 7;   // bound registers on the config port
  localparam int IN_W     = 56;  // input word, padded to bytes
  localparam int OUT_W    = 152; // output word, padded to bytes
  localparam int PCT_W    = 33;
  localparam int SUM_W    = 48;
  localparam int TGT_W    = 48;  // fraction * total, Q16 scaled
  localparam int CUM_W    = 35;  // running sum of up to eight counts
  localparam int NUM_W    = 48;  // interpolation numerator
  localparam int DIFF_W   = 33;  // bound span, overflow bucket doubles

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_QUERY   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [31:0] BOUND_RESET [NUM_REGS] = '{
    32'd1000, 32'd5000, 32'd10000, 32'd50000,
    32'd100000, 32'd500000, 32'd1000000
  };

  // counter store update request and read-back
  typedef struct packed {
    logic        upd;
    logic [2:0]  idx;
    logic [31:0] val;
  } bin_req_t;

  typedef struct packed {
    logic [31:0]      cnt;
    logic [31:0]      total;
    logic [SUM_W-1:0] sum;
  } bin_stat_t;

  // multiply-divide unit: floor(num * mult / (den * 2^16))
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DIFF_W-1:0] mult;
    logic [31:0]       den;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [DIFF_W-1:0] quo;
    logic              inexact;
  } md_rsp_t;

endpackage

// ----- src/latency_histogram_percentile_core.sv -----
// Top level: latency histogram with percentile readout, sequencer and ports.
//
//  channel   | dir | signals                        | word contents (low bit first)
//  ----------+-----+--------------------------------+-------------------------------------
//  s_axis    | in  | tvalid tready tdata[55:0]      | command, value_us, fraction,
//            |     |                                | bucket_select, zero pad
//  m_axis    | out | tvalid tready tdata[151:0]     | percentile_us, bucket_index,
//            |     |                                | bucket_count, total_count, sum_us, pad
//  cfg       | in  | cfg_we cfg_index cfg_data      | bound_0..bound_6 at index 0..6
//
// One word at a time. Read and unused commands go straight to the response;
// observe scans the bounds (one bound compare per cycle), then updates the counters.
// A query walks the buckets and adds one count per cycle, then the
// multiply-divide unit forms the product and then the quotient.
// Reset is synchronous and restores the bounds and clears all counters at once.
// A finished word waits in the output register; the input side reopens as soon
// as that register is loaded, and a held m_axis_tready stalls only the next load.
module latency_histogram_percentile_core #(
  parameter int NUM_BOUNDS  = 7,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // command, value_us, fraction, bucket_select
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [lhp_pkg::IN_W-1:0]  s_axis_tdata,
  // percentile_us, bucket_index, bucket_count, total_count, sum_us
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [lhp_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam logic [2:0] LAST_B = 3'(NUM_BOUNDS - 1);
  localparam logic [2:0] OVF_B  = 3'(NUM_BOUNDS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_OSCAN = 4'd1;
  localparam logic [3:0] ST_OUPD  = 4'd2;
  localparam logic [3:0] ST_QTGT  = 4'd3;
  localparam logic [3:0] ST_QWALK = 4'd4;
  localparam logic [3:0] ST_QSET  = 4'd5;
  localparam logic [3:0] ST_QWAIT = 4'd6;
  localparam logic [3:0] ST_RESP  = 4'd7;

  logic [3:0]                   state;
  logic [31:0]                  bound [lhp_pkg::NUM_REGS];
  logic [1:0]                   cmd_r;
  logic [31:0]                  val_r;
  logic [16:0]                  frac_r;
  logic [2:0]                   idx;
  logic [lhp_pkg::CUM_W-1:0]    cum;
  logic [lhp_pkg::TGT_W-1:0]    target;
  logic [31:0]                  cnt_sel;
  logic [31:0]                  lower;
  logic [lhp_pkg::PCT_W-1:0]    pct;
  logic                         desc;
  logic                         s_acc;
  logic                         out_free;

  logic [31:0]                  bsel;
  logic [lhp_pkg::DIFF_W-1:0]   upper;
  logic [lhp_pkg::DIFF_W-1:0]   low_x;
  logic [16:0]                  fracc;
  logic [lhp_pkg::CUM_W-1:0]    cum_next;
  logic [lhp_pkg::CUM_W+15:0]   t_ext;
  logic [lhp_pkg::CUM_W+15:0]   prev16;
  logic [lhp_pkg::DIFF_W:0]     qc;

  lhp_pkg::bin_req_t  bin_req;
  lhp_pkg::bin_stat_t bin_stat;
  lhp_pkg::md_req_t   md_req;
  lhp_pkg::md_rsp_t   md_rsp;

  lhp_bins #(
    .NUM_BOUNDS  (NUM_BOUNDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bins (
    .clk  (clk),
    .rst  (rst),
    .req  (bin_req),
    .stat (bin_stat)
  );

  lhp_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < lhp_pkg::NUM_REGS; k++) begin
        bound[k] <= lhp_pkg::BOUND_RESET[k];
      end
    end else if (cfg_we) begin
      for (int k = 0; k < lhp_pkg::NUM_REGS; k++) begin
        if (cfg_index == 3'(k)) begin
          bound[k] <= cfg_data;
        end
      end
    end
  end

  // bound of the current bucket; the overflow bucket tops out at twice the last
  always_comb begin
    bsel = '0;
    for (int k = 0; k < lhp_pkg::NUM_REGS; k++) begin
      if (idx == 3'(k)) begin
        bsel = bound[k];
      end
    end
  end

  assign upper    = (idx < OVF_B) ? {1'b0, bsel} : {bound[NUM_BOUNDS-1], 1'b0};
  assign low_x    = {1'b0, lower};
  assign fracc    = (frac_r > lhp_pkg::ONE_Q16) ? lhp_pkg::ONE_Q16 : frac_r;
  assign cum_next = cum + lhp_pkg::CUM_W'(bin_stat.cnt);
  assign t_ext    = (lhp_pkg::CUM_W + 16)'(target);
  assign prev16   = {cum, 16'd0};
  assign qc       = (lhp_pkg::DIFF_W + 1)'(md_rsp.quo) + (lhp_pkg::DIFF_W + 1)'(md_rsp.inexact);

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign bin_req.upd = (state == ST_OUPD);
  assign bin_req.idx = idx;
  assign bin_req.val = val_r;

  assign md_req.start = (state == ST_QSET) && (cnt_sel != '0);
  assign md_req.num   = (t_ext > prev16) ? lhp_pkg::NUM_W'(t_ext - prev16) : '0;
  assign md_req.mult  = (upper >= low_x) ? (upper - low_x) : (low_x - upper);
  assign md_req.den   = cnt_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in ST_RESP the load below decides tvalid on its own
      if (m_axis_tvalid && m_axis_tready && state != ST_RESP) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (s_axis_tdata[1:0])
              lhp_pkg::CMD_OBSERVE: state <= ST_OSCAN;
              lhp_pkg::CMD_QUERY:   state <= ST_QTGT;
              default:              state <= ST_RESP;
            endcase
          end
        end
        ST_OSCAN: begin
          if (val_r <= bsel || idx == LAST_B) begin
            state <= ST_OUPD;
          end
        end
        ST_OUPD: state <= ST_RESP;
        ST_QTGT: begin
          state <= (bin_stat.total == '0) ? ST_RESP : ST_QWALK;
        end
        ST_QWALK: begin
          if (t_ext > {cum_next, 16'd0}) begin
            if (idx == OVF_B) begin
              state <= ST_RESP;
            end
          end else begin
            state <= ST_QSET;
          end
        end
        ST_QSET: state <= (cnt_sel == '0) ? ST_RESP : ST_QWAIT;
        ST_QWAIT: if (md_rsp.done) state <= ST_RESP;
        ST_RESP: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd_r  <= s_axis_tdata[1:0];
        val_r  <= s_axis_tdata[33:2];
        frac_r <= s_axis_tdata[50:34];
        pct    <= '0;
        idx    <= (s_axis_tdata[1:0] == lhp_pkg::CMD_READ) ? s_axis_tdata[53:51] : 3'd0;
      end
      ST_OSCAN: begin
        if (val_r > bsel) begin
          idx <= (idx == LAST_B) ? OVF_B : idx + 1'b1;
        end
      end
      ST_QTGT: begin
        target <= lhp_pkg::TGT_W'(fracc) * lhp_pkg::TGT_W'(bin_stat.total);
        cum    <= '0;
        lower  <= '0;
        idx    <= '0;
      end
      ST_QWALK: begin
        if (t_ext > {cum_next, 16'd0}) begin
          // target not reached: this bound is the next bucket's lower edge
          cum   <= cum_next;
          lower <= bsel;
          if (idx == OVF_B) begin
            pct <= lhp_pkg::PCT_W'(bound[NUM_BOUNDS-1]);
          end else begin
            idx <= idx + 1'b1;
          end
        end else begin
          cnt_sel <= bin_stat.cnt;
        end
      end
      ST_QSET: begin
        desc <= upper < low_x;
        if (cnt_sel == '0) begin
          pct <= upper;
        end
      end
      ST_QWAIT: begin
        if (md_rsp.done) begin
          if (!desc) begin
            pct <= lhp_pkg::PCT_W'(low_x + md_rsp.quo);
          end else if (qc >= (lhp_pkg::DIFF_W + 1)'(lower)) begin
            pct <= '0;
          end else begin
            pct <= lhp_pkg::PCT_W'((lhp_pkg::DIFF_W + 1)'(lower) - qc);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          m_axis_tdata <= {
            4'd0,
            bin_stat.sum,
            bin_stat.total,
            ((cmd_r == lhp_pkg::CMD_OBSERVE || cmd_r == lhp_pkg::CMD_READ)
              ? bin_stat.cnt : 32'd0),
            ((cmd_r == lhp_pkg::CMD_OBSERVE || cmd_r == lhp_pkg::CMD_READ)
              ? idx : 3'd0),
            pct
          };
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/lhp_bins.sv -----
// Bucket counters, observation total and latency sum, all saturating.
module lhp_bins #(
  parameter int NUM_BOUNDS  = 7,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  lhp_pkg::bin_req_t  req,
  output lhp_pkg::bin_stat_t stat
);

  localparam int CW  = (COUNT_WIDTH > 32) ? 32 : COUNT_WIDTH;
  localparam int NBK = NUM_BOUNDS + 1;

  logic [CW-1:0]            cnt [NBK];
  logic [CW-1:0]            total;
  logic [lhp_pkg::SUM_W-1:0] sum;
  logic [CW-1:0]            rd;
  logic [lhp_pkg::SUM_W:0]  sum_add;

  always_comb begin
    rd = '0;
    for (int k = 0; k < NBK; k++) begin
      if (req.idx == 3'(k)) begin
        rd = cnt[k];
      end
    end
  end

  assign sum_add = {1'b0, sum} + (lhp_pkg::SUM_W + 1)'(req.val);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NBK; k++) begin
        cnt[k] <= '0;
      end
      total <= '0;
      sum   <= '0;
    end else if (req.upd) begin
      for (int k = 0; k < NBK; k++) begin
        if (req.idx == 3'(k) && cnt[k] != '1) begin
          cnt[k] <= cnt[k] + 1'b1;
        end
      end
      if (total != '1) begin
        total <= total + 1'b1;
      end
      sum <= sum_add[lhp_pkg::SUM_W] ? '1 : sum_add[lhp_pkg::SUM_W-1:0];
    end
  end

  assign stat.cnt   = 32'(rd);
  assign stat.total = 32'(total);
  assign stat.sum   = sum;

endmodule

// ----- src/lhp_muldiv.sv -----
// Iterative multiply then restoring divide for the bucket interpolation.
module lhp_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  lhp_pkg::md_req_t req,
  output lhp_pkg::md_rsp_t rsp
);

  localparam int NW        = lhp_pkg::NUM_W;
  localparam int DW        = lhp_pkg::DIFF_W;
  localparam int HALF      = NW / 2;
  localparam int PROD_W    = HALF + DW;
  localparam int ACC_W     = NW + DW;
  localparam int DIV_STEPS = DW;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MLO  = 3'd1;
  localparam logic [2:0] PH_MHI  = 3'd2;
  localparam logic [2:0] PH_MACC = 3'd3;
  localparam logic [2:0] PH_DIV  = 3'd4;
  localparam logic [2:0] PH_FIN  = 3'd5;

  logic [2:0]        ph;
  logic [NW-1:0]     num_r;
  logic [DW-1:0]     mul_r;
  logic [31:0]       den_r;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_sum;
  logic [HALF-1:0]   mul_a;
  logic [31:0]       rem;
  logic [DW-1:0]     dq;
  logic              sticky;
  logic [5:0]        step;
  logic [32:0]       trial;
  logic              ge;

  // single shared multiplier, one half of the numerator per cycle
  assign mul_a   = (ph == PH_MLO) ? num_r[HALF-1:0] : num_r[NW-1:HALF];
  assign acc_sum = acc + {prod, HALF'(0)};
  assign trial   = {rem, dq[DW-1]};
  assign ge      = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE;
    end else begin
      case (ph)
        PH_IDLE: if (req.start) ph <= PH_MLO;
        PH_MLO:  ph <= PH_MHI;
        PH_MHI:  ph <= PH_MACC;
        PH_MACC: ph <= PH_DIV;
        PH_DIV:  if (step == 6'(DIV_STEPS - 1)) ph <= PH_FIN;
        default: ph <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ph)
      PH_IDLE: begin
        num_r <= req.num;
        mul_r <= req.mult;
        den_r <= req.den;
      end
      PH_MLO: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_r);
      end
      PH_MHI: begin
        acc  <= ACC_W'(prod);
        prod <= PROD_W'(mul_a) * PROD_W'(mul_r);
      end
      PH_MACC: begin
        // drop the Q16 scale of the divisor: sticky keeps the lost bits
        rem    <= acc_sum[ACC_W-1:16+DW];
        dq     <= acc_sum[16+DW-1:16];
        sticky <= |acc_sum[15:0];
        step   <= '0;
      end
      PH_DIV: begin
        rem  <= ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        dq   <= {dq[DW-2:0], ge};
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rsp.done    = (ph == PH_FIN);
  assign rsp.quo     = dq;
  assign rsp.inexact = (rem != '0) || sticky;

endmodule

// ----- src/lhp_checker.sv -----
// Port-level checks for the latency histogram percentile core, bound to the top.
module lhp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata
);

  logic [31:0] last_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_total <= m_axis_tdata[99:68];
    end
  end

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

  // one word in flight: input closes after each accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a nonzero percentile only comes from a query, which carries no bucket
  a_query_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[32:0] != 33'd0)) |-> (m_axis_tdata[67:33] == 35'd0))
    else $error("percentile word carries bucket fields");

  // saturating total never goes back
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |-> (m_axis_tdata[99:68] >= last_total))
    else $error("total count decreased");

endmodule

bind latency_histogram_percentile_core lhp_checker u_lhp_checker (.*);
